// ===== rtl/core/set_assoc_lru_cache_model_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_CORE_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SALC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("salc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SALC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("salc assertion failed");

`endif

// ===== rtl/core/salc_pkg.sv =====
package salc_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 48;

  // Fixed field widths.
  localparam int ADDR_FIELD_W = 48;
  localparam int CNT_W        = 32;
  localparam int SET_BITS_W   = 3;
  localparam int BLOCK_BITS_W = 5;
  localparam int WAYS_W       = 4;
  localparam int CFG_DATA_W   = 5;
  localparam int CFG_IDX_W    = 2;

  // Register reset values.
  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd0;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_STORE  = 2'd1,
    ACT_MODIFY = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]              action;
    logic [ADDR_FIELD_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]       hits_added;
    logic             was_miss;
    logic             was_eviction;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } rsp_t;

  // Status of one set update.
  typedef struct packed {
    logic update;
    logic hit;
    logic miss;
    logic evict;
    logic modify;
  } lookup_t;

endpackage

// ===== rtl/core/salc_set_update.sv =====
// Tag match, fill/victim choice and LRU rank update for one set row.
module salc_set_update #(
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF,
  parameter int TAG_W    = salc_pkg::ADDR_FIELD_W,
  parameter int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  parameter int WCNT_W   = $clog2(MAX_WAYS + 1)
) (
  input  logic [1:0]                       action,
  input  logic [WCNT_W-1:0]                ways,
  input  logic [TAG_W-1:0]                 tag_in,
  input  logic [MAX_WAYS-1:0]              valid_i,
  input  logic [MAX_WAYS-1:0][RANK_W-1:0]  rank_i,
  input  logic [MAX_WAYS-1:0][TAG_W-1:0]   tag_i,
  output logic [MAX_WAYS-1:0]              valid_o,
  output logic [MAX_WAYS-1:0][RANK_W-1:0]  rank_o,
  output logic [MAX_WAYS-1:0][TAG_W-1:0]   tag_o,
  output salc_pkg::lookup_t                status
);

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] free_vec;
  logic                found;
  logic                has_free;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    vic_way;
  logic [RANK_W-1:0]   best;
  logic [WAY_W-1:0]    way_sel;
  logic [RANK_W:0]     old_rank;
  logic                update;

  assign update = (action == salc_pkg::ACT_LOAD) || (action == salc_pkg::ACT_STORE) ||
                  (action == salc_pkg::ACT_MODIFY);

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]   = (WCNT_W'(w) < ways);
      hit_vec[w]  = in_use[w] && valid_i[w] && (tag_i[w] == tag_in);
      free_vec[w] = in_use[w] && !valid_i[w];
    end
  end

  // First matching way, first free way, first way with the oldest rank.
  always_comb begin
    found    = 1'b0;
    has_free = 1'b0;
    hit_way  = '0;
    free_way = '0;
    vic_way  = '0;
    best     = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (hit_vec[w] && !found) begin
        found   = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (free_vec[w] && !has_free) begin
        has_free = 1'b1;
        free_way = WAY_W'(w);
      end
      if (in_use[w] && (rank_i[w] > best)) begin
        best    = rank_i[w];
        vic_way = WAY_W'(w);
      end
    end
  end

  assign way_sel  = found ? hit_way : (has_free ? free_way : vic_way);
  assign old_rank = valid_i[way_sel] ? {1'b0, rank_i[way_sel]} : (RANK_W+1)'(MAX_WAYS);

  // A modify's second touch hits a rank-0 line and changes nothing.
  always_comb begin
    valid_o = valid_i;
    rank_o  = rank_i;
    tag_o   = tag_i;
    if (update) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (in_use[w] && valid_i[w] && (WAY_W'(w) != way_sel) &&
            ({1'b0, rank_i[w]} < old_rank) && (rank_i[w] != RANK_W'(MAX_WAYS - 1))) begin
          rank_o[w] = rank_i[w] + 1'b1;
        end
      end
      rank_o[way_sel]  = '0;
      valid_o[way_sel] = 1'b1;
      tag_o[way_sel]   = tag_in;
    end
  end

  assign status.update = update;
  assign status.hit    = update && found;
  assign status.miss   = update && !found;
  assign status.evict  = update && !found && !has_free;
  assign status.modify = (action == salc_pkg::ACT_MODIFY);

endmodule

// ===== rtl/core/set_assoc_lru_cache_model_core.sv =====
// Set-associative LRU cache model with hit/miss/eviction counters.
// The result strobe out_valid follows a taken start beat through s1_valid_r and out_valid_r.
// Throughput: one access per cycle; busy is always low (no clearing pass).
// Each access reads a set row; load/store/modify write it back; same-set writes forward.
// Reset (rst_n low, synchronous): all lines invalid, ranks 0, totals 0, config defaults.
module set_assoc_lru_cache_model_core #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  salc_pkg::req_t                      in_data,
  output logic                                out_valid,
  output salc_pkg::rsp_t                      out_data,
  input  logic                                cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  // Tag keeps every used address bit.
  localparam int TAG_W    = (ADDR_WIDTH < salc_pkg::ADDR_FIELD_W) ? ADDR_WIDTH :
                            salc_pkg::ADDR_FIELD_W;
  localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int ROW_W    = MAX_WAYS * (1 + RANK_W + TAG_W);
  localparam int CNT_W    = salc_pkg::CNT_W;

  // ---------------------------------------------------------------- config
  logic [salc_pkg::SET_BITS_W-1:0]   set_bits_r;
  logic [salc_pkg::BLOCK_BITS_W-1:0] block_bits_r;
  logic [salc_pkg::WAYS_W-1:0]       ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= salc_pkg::SET_BITS_RST;
      block_bits_r <= salc_pkg::BLOCK_BITS_RST;
      ways_r       <= salc_pkg::WAYS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        salc_pkg::CFG_SET_BITS:   set_bits_r   <= cfg_wdata[salc_pkg::SET_BITS_W-1:0];
        salc_pkg::CFG_BLOCK_BITS: block_bits_r <= cfg_wdata[salc_pkg::BLOCK_BITS_W-1:0];
        salc_pkg::CFG_WAYS:       ways_r       <= cfg_wdata[salc_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped set bits and associativity.
  logic [salc_pkg::SET_BITS_W-1:0] sb_eff;
  logic [WCNT_W-1:0]               ways_eff;

  assign sb_eff = (32'(set_bits_r) > MAX_SET_BITS) ? salc_pkg::SET_BITS_W'(MAX_SET_BITS) :
                  set_bits_r;

  always_comb begin
    if (ways_r == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (32'(ways_r) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_r);
    end
  end

  // ---------------------------------------------------------------- stage 0: split address
  logic             in_fire;
  logic [TAG_W-1:0] addr_eff;
  logic [TAG_W-1:0] addr_off;
  logic [SET_W-1:0] set_mask;
  logic [SET_W-1:0] set_s0;
  logic [TAG_W-1:0] tag_s0;
  logic [5:0]       tag_shift;

  assign busy      = 1'b0;
  assign in_fire   = start && !busy;
  assign addr_eff  = in_data.address[TAG_W-1:0];
  assign addr_off  = addr_eff >> block_bits_r;
  assign set_mask  = ~({SET_W{1'b1}} << sb_eff);
  assign set_s0    = addr_off[SET_W-1:0] & set_mask;
  assign tag_shift = 6'(block_bits_r) + 6'(sb_eff);
  assign tag_s0    = addr_eff >> tag_shift;

  // ---------------------------------------------------------------- set store
  // One row per set: {valid bits, ranks, tags}. Rows never written read as empty.
  logic [ROW_W-1:0]    mem [NUM_SETS];
  logic [ROW_W-1:0]    rd_row_r;
  logic [NUM_SETS-1:0] row_written_r;

  logic             s1_valid_r;
  logic [1:0]       s1_action_r;
  logic [SET_W-1:0] s1_set_r;
  logic [TAG_W-1:0] s1_tag_r;
  logic             byp_r;
  logic [ROW_W-1:0] byp_row_r;

  logic             wr_en;
  logic [ROW_W-1:0] wr_row;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_set_r] <= wr_row;
    end
    if (in_fire) begin
      rd_row_r <= mem[set_s0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_written_r <= '0;
    end else if (wr_en) begin
      row_written_r[s1_set_r] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      // Row read this edge misses the write landing at the same edge.
      byp_r      <= in_fire && wr_en && (set_s0 == s1_set_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= in_data.action;
      s1_set_r    <= set_s0;
      s1_tag_r    <= tag_s0;
    end
    if (wr_en) begin
      byp_row_r <= wr_row;
    end
  end

  // ---------------------------------------------------------------- stage 1: lookup/update
  logic [ROW_W-1:0]                  row_cur;
  logic                              row_live;
  logic [MAX_WAYS-1:0]               valid_cur;
  logic [MAX_WAYS-1:0][RANK_W-1:0]   rank_cur;
  logic [MAX_WAYS-1:0][TAG_W-1:0]    tag_cur;
  logic [MAX_WAYS-1:0]               valid_new;
  logic [MAX_WAYS-1:0][RANK_W-1:0]   rank_new;
  logic [MAX_WAYS-1:0][TAG_W-1:0]    tag_new;
  salc_pkg::lookup_t                 lk;

  assign row_cur   = byp_r ? byp_row_r : rd_row_r;
  assign row_live  = byp_r || row_written_r[s1_set_r];
  assign valid_cur = row_live ? row_cur[ROW_W-1 -: MAX_WAYS] : '0;
  assign rank_cur  = row_live ? row_cur[TAG_W*MAX_WAYS +: RANK_W*MAX_WAYS] : '0;
  assign tag_cur   = row_cur[0 +: TAG_W*MAX_WAYS];

  salc_set_update #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TAG_W),
    .RANK_W   (RANK_W),
    .WCNT_W   (WCNT_W)
  ) u_upd (
    .action  (s1_action_r),
    .ways    (ways_eff),
    .tag_in  (s1_tag_r),
    .valid_i (valid_cur),
    .rank_i  (rank_cur),
    .tag_i   (tag_cur),
    .valid_o (valid_new),
    .rank_o  (rank_new),
    .tag_o   (tag_new),
    .status  (lk)
  );

  assign wr_en  = s1_valid_r && lk.update;
  assign wr_row = {valid_new, rank_new, tag_new};

  // ---------------------------------------------------------------- counters and result
  logic [1:0]       hits_add;
  logic [CNT_W:0]   hit_sum;
  logic [CNT_W:0]   miss_sum;
  logic [CNT_W:0]   evict_sum;
  logic [CNT_W-1:0] hit_cnt_r,   hit_cnt_nxt;
  logic [CNT_W-1:0] miss_cnt_r,  miss_cnt_nxt;
  logic [CNT_W-1:0] evict_cnt_r, evict_cnt_nxt;
  logic             out_valid_r;
  salc_pkg::rsp_t   out_data_r;

  // A modify adds a second hit on top of the first lookup.
  assign hits_add  = lk.update ? (2'(lk.hit) + 2'(lk.modify)) : 2'd0;
  assign hit_sum   = {1'b0, hit_cnt_r} + (CNT_W+1)'(hits_add);
  assign miss_sum  = {1'b0, miss_cnt_r} + (CNT_W+1)'(lk.miss);
  assign evict_sum = {1'b0, evict_cnt_r} + (CNT_W+1)'(lk.evict);

  // Saturate at all ones.
  assign hit_cnt_nxt   = hit_sum[CNT_W]   ? '1 : hit_sum[CNT_W-1:0];
  assign miss_cnt_nxt  = miss_sum[CNT_W]  ? '1 : miss_sum[CNT_W-1:0];
  assign evict_cnt_nxt = evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        evict_cnt_r <= evict_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_data_r.hits_added     <= hits_add;
      out_data_r.was_miss       <= lk.miss;
      out_data_r.was_eviction   <= lk.evict;
      out_data_r.hit_total      <= hit_cnt_nxt;
      out_data_r.miss_total     <= miss_cnt_nxt;
      out_data_r.eviction_total <= evict_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/salc_checker.sv =====
`include "set_assoc_lru_cache_model_core_assert.svh"

// Port-level checks on the cache model core.
module salc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input salc_pkg::rsp_t out_data
);

  `SALC_ASSERT_IMPL(a_beat_gives_result, start && !busy, ##2 out_valid)
  `SALC_ASSERT_IMPL(a_no_beat_no_result, !(start && !busy), ##2 !out_valid)
  `SALC_ASSERT_IMPL(a_evict_is_miss, out_valid && out_data.was_eviction, out_data.was_miss)
  `SALC_ASSERT_IMPL(a_two_hits_no_miss, out_valid && (out_data.hits_added == 2'd2), !out_data.was_miss)

endmodule

bind set_assoc_lru_cache_model_core salc_checker u_salc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== test/set_assoc_lru_cache_model_core_tb.sv =====
module set_assoc_lru_cache_model_core_tb;

  localparam int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF;
  localparam int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF;
  localparam int ADDR_FIELD_W = salc_pkg::ADDR_FIELD_W;
  localparam int CNT_W        = salc_pkg::CNT_W;
  localparam int SET_BITS_W   = salc_pkg::SET_BITS_W;
  localparam int BLOCK_BITS_W = salc_pkg::BLOCK_BITS_W;
  localparam int WAYS_W       = salc_pkg::WAYS_W;
  localparam int CFG_IDX_W    = salc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = salc_pkg::CFG_DATA_W;
  localparam int NUM_LINES    = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int RANK_W       = $clog2(MAX_WAYS);
  localparam int DRAIN_CYCLES = 6;     // settling margin after the last result
  localparam int STALL_LIMIT  = 1000;  // cycles with no beat on either side
  localparam int GAP_PCT      = 17;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 63;

  // Action code the block must ignore.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  salc_pkg::req_t in_data;
  logic out_valid;
  salc_pkg::rsp_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  set_assoc_lru_cache_model_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the cache: line store, LRU ranks, totals and the config registers.
  // Line (set, way) sits at set * MAX_WAYS + way.
  // ---------------------------------------------------------------------------
  bit                      line_ok   [NUM_LINES];
  logic [ADDR_FIELD_W-1:0] line_tag_q[NUM_LINES];
  bit [RANK_W-1:0]         line_rank [NUM_LINES];
  bit [CNT_W-1:0]          hit_count;
  bit [CNT_W-1:0]          miss_count;
  bit [CNT_W-1:0]          evict_count;

  logic [SET_BITS_W-1:0]   cfg_set_bits   = salc_pkg::SET_BITS_RST;
  logic [BLOCK_BITS_W-1:0] cfg_block_bits = salc_pkg::BLOCK_BITS_RST;
  logic [WAYS_W-1:0]       cfg_ways       = salc_pkg::WAYS_RST;

  salc_pkg::rsp_t pending_rsp_q[$];  // results predicted for accepted beats, oldest first
  salc_pkg::rsp_t rsp_head;
  int   err_count;
  int   stall_cycles;
  bit   gaps_on = 1'b1;

  function automatic int eff_set_bits();
    return (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
  endfunction

  // Zero ways means one; anything above the store's width is clipped.
  function automatic int eff_ways();
    if (cfg_ways == 0) return 1;
    return (cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways);
  endfunction

  function automatic bit [CNT_W-1:0] sat_inc(bit [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Make way w most recently used. Lines younger than w's old rank age by one;
  // an invalid w counts as older than everything.
  function automatic void lru_touch(int base, int ways, int w);
    int old;
    old = line_ok[base + w] ? int'(line_rank[base + w]) : MAX_WAYS;
    for (int i = 0; i < ways; i++) begin
      if (i != w && line_ok[base + i] && line_rank[base + i] < old &&
          line_rank[base + i] < MAX_WAYS - 1)
        line_rank[base + i] = line_rank[base + i] + 1'b1;
    end
    line_rank[base + w] = '0;
  endfunction

  // Lookup, fill/evict and LRU update for one access; returns the result beat.
  function automatic salc_pkg::rsp_t predict_access(salc_pkg::req_t r);
    salc_pkg::rsp_t res;
    int sb, ways, base, way, best;
    bit found, empty;
    logic [ADDR_FIELD_W-1:0] set_sel, tag;
    res = '0;
    sb = eff_set_bits();
    ways = eff_ways();
    if (r.action != ACT_UNUSED) begin
      set_sel = (r.address >> cfg_block_bits) & ((48'd1 << sb) - 48'd1);
      tag = r.address >> (cfg_block_bits + sb);
      base = int'(set_sel) * MAX_WAYS;
      found = 1'b0;
      way = 0;
      for (int w = 0; w < ways && !found; w++) begin
        if (line_ok[base + w] && line_tag_q[base + w] == tag) begin
          found = 1'b1;
          way = w;
        end
      end
      if (found) begin
        res.hits_added = 2'd1;
        hit_count = sat_inc(hit_count);
      end else begin
        res.was_miss = 1'b1;
        miss_count = sat_inc(miss_count);
        empty = 1'b0;
        for (int w = 0; w < ways && !empty; w++) begin
          if (!line_ok[base + w]) begin
            empty = 1'b1;
            way = w;
          end
        end
        if (!empty) begin
          // victim: first way holding the greatest rank
          res.was_eviction = 1'b1;
          evict_count = sat_inc(evict_count);
          best = 0;
          way = 0;
          for (int w = 0; w < ways; w++) begin
            if (line_rank[base + w] > best) begin
              best = int'(line_rank[base + w]);
              way = w;
            end
          end
        end
      end
      lru_touch(base, ways, way);
      line_ok[base + way] = 1'b1;
      line_tag_q[base + way] = tag;
      if (r.action == salc_pkg::ACT_MODIFY) begin
        // the store half of a modify always hits the line just touched
        lru_touch(base, ways, way);
        res.hits_added = res.hits_added + 2'd1;
        hit_count = sat_inc(hit_count);
      end
    end
    res.hit_total = hit_count;
    res.miss_total = miss_count;
    res.eviction_total = evict_count;
    return res;
  endfunction

  function automatic logic [ADDR_FIELD_W-1:0] rand48();
    return ADDR_FIELD_W'({$urandom, $urandom});
  endfunction

  // Build an address from tag, set and offset under the current config.
  function automatic logic [ADDR_FIELD_W-1:0] make_addr(logic [ADDR_FIELD_W-1:0] tag,
                                                        int set_no,
                                                        logic [ADDR_FIELD_W-1:0] off);
    return (tag << (cfg_block_bits + eff_set_bits())) |
           (ADDR_FIELD_W'(set_no) << cfg_block_bits) |
           (off & ((48'd1 << cfg_block_bits) - 48'd1));
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
    if (err_count < 40)
      $display("ERROR @%0t: %s got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  // Outputs are sampled at the rising edge; each strobed beat is taken then.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("result beat with nothing pending, hit_total", out_data.hit_total, '0);
      end else begin
        rsp_head = pending_rsp_q.pop_front();
        if (out_data.hits_added !== rsp_head.hits_added)
          report_mismatch("hits_added", CNT_W'(out_data.hits_added),
                          CNT_W'(rsp_head.hits_added));
        if (out_data.was_miss !== rsp_head.was_miss)
          report_mismatch("was_miss", CNT_W'(out_data.was_miss), CNT_W'(rsp_head.was_miss));
        if (out_data.was_eviction !== rsp_head.was_eviction)
          report_mismatch("was_eviction", CNT_W'(out_data.was_eviction),
                          CNT_W'(rsp_head.was_eviction));
        if (out_data.hit_total !== rsp_head.hit_total)
          report_mismatch("hit_total", out_data.hit_total, rsp_head.hit_total);
        if (out_data.miss_total !== rsp_head.miss_total)
          report_mismatch("miss_total", out_data.miss_total, rsp_head.miss_total);
        if (out_data.eviction_total !== rsp_head.eviction_total)
          report_mismatch("eviction_total", out_data.eviction_total, rsp_head.eviction_total);
      end
    end
  end

  // Watchdog: ends the run if neither an access nor a result moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Inputs change on the falling edge only.
  // ---------------------------------------------------------------------------

  // One access beat; start stays high afterwards unless the next call idles.
  task automatic send_access(logic [1:0] act, logic [ADDR_FIELD_W-1:0] addr);
    salc_pkg::req_t r;
    r.action = act;
    r.address = addr;
    @(negedge clk);
    // idle cycles drawn one at a time, about GAP_PCT in a hundred
    while (gaps_on && $urandom_range(99) < GAP_PCT) begin
      start <= 1'b0;
      in_data <= salc_pkg::req_t'({2'($urandom), rand48()});
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rsp_q.push_back(predict_access(r));
  endtask

  // Stop sending and let every predicted result come back, then settle.
  task automatic wait_all_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(salc_pkg::cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      salc_pkg::CFG_SET_BITS:   cfg_set_bits = val[SET_BITS_W-1:0];
      salc_pkg::CFG_BLOCK_BITS: cfg_block_bits = val[BLOCK_BITS_W-1:0];
      salc_pkg::CFG_WAYS:       cfg_ways = val[WAYS_W-1:0];
      default: ;
    endcase
  endtask

  // Registers change only with the block idle; the store is left as it is.
  task automatic apply_config(logic [SET_BITS_W-1:0] sb, logic [BLOCK_BITS_W-1:0] bb,
                              logic [WAYS_W-1:0] wy);
    wait_all_results();
    write_cfg(salc_pkg::CFG_SET_BITS, CFG_DATA_W'(sb));
    write_cfg(salc_pkg::CFG_BLOCK_BITS, CFG_DATA_W'(bb));
    write_cfg(salc_pkg::CFG_WAYS, CFG_DATA_W'(wy));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset config: 16-byte blocks, one set, one way.
  task automatic test_default_config();
    send_access(salc_pkg::ACT_LOAD, 48'h0);
    send_access(salc_pkg::ACT_LOAD, 48'hF);     // same block: hit
    send_access(salc_pkg::ACT_STORE, 48'h10);   // next block: evicts the only line
    send_access(salc_pkg::ACT_MODIFY, 48'h10);  // two hits
    send_access(ACT_UNUSED, 48'h0);             // ignored, totals echoed
  endtask

  // Register and address extremes, clipping of set bits and ways.
  task automatic test_field_extremes();
    apply_config(3'd7, 5'd31, 4'd15);
    send_access(salc_pkg::ACT_LOAD, '1);
    send_access(salc_pkg::ACT_MODIFY, '1);
    send_access(salc_pkg::ACT_STORE, '0);
    send_access(salc_pkg::ACT_LOAD, 48'hAAAA_AAAA_AAAA);
    send_access(salc_pkg::ACT_LOAD, 48'h5555_5555_5555);
    apply_config(3'd6, 5'd0, 4'd0);   // zero ways acts as one
    send_access(salc_pkg::ACT_LOAD, 48'h0);
    send_access(salc_pkg::ACT_LOAD, 48'h40);    // set 0, new tag: eviction
    send_access(salc_pkg::ACT_MODIFY, 48'h3F);  // top set
  endtask

  // Fill a 4-way set, then check LRU victim choice.
  task automatic test_lru_replacement();
    apply_config(3'd1, 5'd4, 4'd4);
    for (int t = 0; t < 4; t++)
      send_access(salc_pkg::ACT_LOAD, make_addr(ADDR_FIELD_W'(t), 0, 0));
    send_access(salc_pkg::ACT_LOAD, make_addr(48'd0, 0, 48'd5));     // hit, refresh tag 0
    send_access(salc_pkg::ACT_STORE, make_addr(48'd4, 0, 48'd3));    // evicts tag 1
    send_access(salc_pkg::ACT_LOAD, make_addr(48'd1, 0, 48'd0));     // evicts tag 2
    send_access(salc_pkg::ACT_MODIFY, make_addr(48'd0, 1, 48'd0));   // other set
  endtask

  // Store survives config changes; lines past ways_in_use go unseen.
  task automatic test_config_change();
    apply_config(3'd1, 5'd4, 4'd2);
    send_access(salc_pkg::ACT_LOAD, make_addr(48'd3, 0, 48'd0));
    apply_config(3'd1, 5'd4, 4'd4);
    send_access(salc_pkg::ACT_LOAD, make_addr(48'd3, 0, 48'd0));
    apply_config(3'd0, 5'd4, 4'd4);
    send_access(salc_pkg::ACT_STORE, 48'h20);
  endtask

  // Random traffic over several configs. Most addresses reuse a small tag pool
  // so sets fill, hit and evict; the rest are full-width noise.
  task automatic test_random_traffic();
    logic [SET_BITS_W-1:0]   sb_list[RAND_PHASES] = '{3'd0, 3'd2, 3'd6, 3'd3, 3'd7, 3'd1, 3'd4, 3'd5};
    logic [BLOCK_BITS_W-1:0] bb_list[RAND_PHASES] = '{5'd4, 5'd4, 5'd0, 5'd16, 5'd31, 5'd5, 5'd8, 5'd2};
    logic [WAYS_W-1:0]       wy_list[RAND_PHASES] = '{4'd1, 4'd4, 4'd8, 4'd2, 4'd15, 4'd0, 4'd8, 4'd3};
    logic [ADDR_FIELD_W-1:0] tag_pool[MAX_WAYS + 2];
    logic [ADDR_FIELD_W-1:0] addr;
    logic [1:0] act;
    int pool_n, sent;
    for (int p = 0; p < RAND_PHASES; p++) begin
      apply_config(sb_list[p], bb_list[p], wy_list[p]);
      gaps_on = (p != 3);  // one phase runs back to back
      pool_n = eff_ways() + 2;
      for (int i = 0; i < pool_n; i++)
        tag_pool[i] = $urandom_range(1) ? ADDR_FIELD_W'(i) : rand48();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        act = ($urandom_range(99) < 4) ? ACT_UNUSED :
              2'($urandom_range(salc_pkg::ACT_MODIFY));
        if ($urandom_range(99) < 15)
          addr = rand48();
        else
          addr = make_addr(tag_pool[$urandom_range(pool_n - 1)],
                           $urandom_range((1 << eff_set_bits()) - 1), rand48());
        send_access(act, addr);
        if (act != ACT_UNUSED) sent++;
        if (p == 5 && sent == PHASE_ITEMS / 2)
          wait_all_results();  // sender holds off until the pipe is empty
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    err_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_config();
    test_field_extremes();
    test_lru_replacement();
    test_config_change();
    test_random_traffic();

    wait_all_results();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
